@@ rtl/core/pcsp_pkg.sv @@
package pcsp_pkg;

	localparam int ADDR_BITS     = 48;
	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int STRIDE_W      = ADDR_BITS + 1;
	localparam int CONF_W        = 2;
	localparam int SHIFT_W       = 4;

	localparam logic [CONF_W-1:0]  CONF_MAX           = 2'd3;
	localparam logic [SHIFT_W-1:0] LINE_SIZE_LOG2_RST = 4'd6;

	// one input beat
	typedef struct packed {
		logic [ADDR_BITS-1:0] access_addr;
		logic [ADDR_BITS-1:0] access_pc;
		logic                 is_prefetch;
	} access_t;

	// one result beat
	typedef struct packed {
		logic [ADDR_BITS-1:0] prefetch_addr;
		logic [ADDR_BITS-1:0] origin_pc;
	} prefetch_t;

	// one table entry
	typedef struct packed {
		logic [ADDR_BITS-1:0] tag_pc;
		logic [ADDR_BITS-1:0] prev_line;
		logic [STRIDE_W-1:0]  stride;
		logic [CONF_W-1:0]    conf;
	} entry_t;

	// confident entry handed to the address stage
	typedef struct packed {
		logic                 go;
		logic [ADDR_BITS-1:0] line;
		logic [STRIDE_W-1:0]  stride;
		logic [ADDR_BITS-1:0] pc;
	} issue_req_t;

endpackage

@@ rtl/core/pcsp_table.sv @@
module pcsp_table
	import pcsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_data,
	input  logic [IDX_W-1:0] vld_idx,
	output logic             vld,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  entry_t           wr_data
);

	entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;

	// entry storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

	// per-entry valid flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	assign vld = vld_q[vld_idx];

endmodule

@@ rtl/core/pcsp_issue.sv @@
module pcsp_issue
	import pcsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  issue_req_t         req,
	input  logic [SHIFT_W-1:0] shamt,
	output logic               done,
	output prefetch_t          result
);

	logic                 go_s2;
	logic [ADDR_BITS-1:0] line_s2;
	logic [STRIDE_W-1:0]  stride_s2;
	logic [ADDR_BITS-1:0] pc_s2;
	logic                 go_s3;
	logic [ADDR_BITS-1:0] sum_s3;
	logic [ADDR_BITS-1:0] pc_s3;
	logic                 done_q;
	prefetch_t            result_q;

	logic [STRIDE_W-1:0]  mag;
	logic                 neg;
	logic [ADDR_BITS-1:0] sum;

	// control valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s2  <= 1'b0;
			go_s3  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_s2  <= req.go;
			go_s3  <= go_s2 & ~neg;
			done_q <= go_s3;
		end
	end

	// next line and underflow check
	always_comb begin
		mag = '0 - stride_s2;
		neg = stride_s2[STRIDE_W-1] && (mag > {1'b0, line_s2});
		sum = line_s2 + stride_s2[ADDR_BITS-1:0];
	end

	// payload stages, line back to byte address
	always_ff @(posedge clk) begin
		line_s2   <= req.line;
		stride_s2 <= req.stride;
		pc_s2     <= req.pc;
		sum_s3    <= sum;
		pc_s3     <= pc_s2;
		result_q.prefetch_addr <= sum_s3 << shamt;
		result_q.origin_pc     <= pc_s3;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/pc_stride_prefetcher.sv @@
// pc-indexed stride prefetcher
// done/result path: table read, lookup stage s1, issue stages s2 and s3, then the output registers
// throughput: one access per cycle, busy stays low; table read registered at the
// accepting edge, update and write back in the next cycle, forwarding the last write
// reset: all entries invalid, line_size_log2 = 6; results cannot be stalled
module pc_stride_prefetcher
	import pcsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  access_t            access,
	input  logic               cfg_we,
	input  logic [SHIFT_W-1:0] cfg_wdata,
	output logic               done,
	output prefetch_t          result
);

	logic [SHIFT_W-1:0]   line_size_log2_q;
	logic                 vld_s1;
	logic [ADDR_BITS-1:0] pc_s1;
	logic [ADDR_BITS-1:0] line_s1;
	logic                 fwd_vld_q;
	logic [IDX_W-1:0]     fwd_idx_q;
	entry_t               fwd_entry_q;

	logic       take;
	entry_t     rd_data;
	logic       ent_vld;
	entry_t     cur;
	entry_t     nxt;
	logic       hit;
	logic       same;
	logic [STRIDE_W-1:0] stride_new;
	issue_req_t req;

	assign busy = 1'b0;
	assign take = start & ~busy & ~access.is_prefetch;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_size_log2_q <= LINE_SIZE_LOG2_RST;
		end else if (cfg_we) begin
			line_size_log2_q <= cfg_wdata;
		end
	end

	// lookup stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			vld_s1 <= take;
			if (vld_s1) begin
				fwd_vld_q <= 1'b1;
			end
		end
	end

	// lookup stage payload and last write for forwarding
	always_ff @(posedge clk) begin
		pc_s1   <= access.access_pc;
		line_s1 <= access.access_addr >> line_size_log2_q;
		if (vld_s1) begin
			fwd_idx_q   <= pc_s1[IDX_W-1:0];
			fwd_entry_q <= nxt;
		end
	end

	pcsp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_idx  (access.access_pc[IDX_W-1:0]),
		.rd_data (rd_data),
		.vld_idx (pc_s1[IDX_W-1:0]),
		.vld     (ent_vld),
		.wr_en   (vld_s1),
		.wr_idx  (pc_s1[IDX_W-1:0]),
		.wr_data (nxt)
	);

	// entry update: allocate on miss, train stride and confidence on hit
	always_comb begin
		cur = (fwd_vld_q && fwd_idx_q == pc_s1[IDX_W-1:0]) ? fwd_entry_q : rd_data;
		hit = ent_vld && (cur.tag_pc == pc_s1);
		stride_new = {1'b0, line_s1} - {1'b0, cur.prev_line};
		same = (stride_new == cur.stride) && (stride_new != '0);
		nxt.tag_pc    = pc_s1;
		nxt.prev_line = line_s1;
		if (!hit) begin
			nxt.stride = '0;
			nxt.conf   = '0;
		end else if (same) begin
			nxt.stride = cur.stride;
			nxt.conf   = (cur.conf == CONF_MAX) ? CONF_MAX : cur.conf + 1'b1;
		end else begin
			nxt.stride = stride_new;
			nxt.conf   = '0;
		end
		req.go     = vld_s1 && hit && (nxt.conf != '0);
		req.line   = line_s1;
		req.stride = nxt.stride;
		req.pc     = pc_s1;
	end

	pcsp_issue u_issue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.shamt  (line_size_log2_q),
		.done   (done),
		.result (result)
	);

	// every demand beat updates its entry in the next cycle
	a_upd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !access.is_prefetch) |=> vld_s1)
		else $error("demand beat did not reach table update");

	// a result comes only from a demand beat that has passed the lookup and issue stages
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && !access.is_prefetch, 4))
		else $error("result without a matching demand beat");

	// result carries the pc of that beat
	a_done_pc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.origin_pc == $past(access.access_pc, 4)))
		else $error("origin pc mismatch");

endmodule
